>>> sv/dual_ir_distance_ema_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the dual IR distance front end
// Shared checking shorthand, clocked on clk_i and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef DUAL_IR_DISTANCE_EMA_MACROS_SVH
`define DUAL_IR_DISTANCE_EMA_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DIDE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DIDE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/dide_pkg.sv
// ----------------------------------------------------------------------------
// Dual IR distance front end package
// Widths, beat layouts, register indexes and reset values.
// ----------------------------------------------------------------------------
package dide_pkg;

  // Sample and field widths
  localparam int unsigned SAMPLE_BITS = 12;
  localparam int unsigned STAMP_W     = 32;
  localparam int unsigned DIST_W      = 32;
  localparam int unsigned ALPHA_W     = 16;
  localparam int unsigned GAIN_W      = 16;
  localparam int unsigned SCALE_W     = 16;
  localparam int unsigned OFFSET_W    = 32;
  localparam int unsigned LIMIT_W     = 12;
  localparam int unsigned STATUS_W    = 2;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Ratio and root arithmetic
  localparam int unsigned FRAC_W     = 32;
  localparam int unsigned NUM_W      = SCALE_W + FRAC_W;
  localparam int unsigned ROOT_W     = NUM_W / 2;
  localparam int unsigned REM_W      = ROOT_W + 3;
  localparam int unsigned CNT_W      = $clog2(NUM_W);
  localparam int unsigned MUL_A_W    = GAIN_W + 1;
  localparam int unsigned MUL_B_W    = ROOT_W + 1;
  localparam int unsigned PROD_W     = MUL_A_W + MUL_B_W;
  localparam int unsigned EMA_SHIFT  = 16;
  localparam int unsigned GAIN_SHIFT = 8;
  localparam int unsigned SUM_W      = DIST_W + 2;
  localparam int unsigned CMP_W      = (SAMPLE_BITS > LIMIT_W) ? SAMPLE_BITS : LIMIT_W;

  // Input beat layout: sample_one, stamp_one, sample_two, stamp_two
  localparam int unsigned IN_S1_LSB  = 0;
  localparam int unsigned IN_T1_LSB  = IN_S1_LSB + SAMPLE_BITS;
  localparam int unsigned IN_S2_LSB  = IN_T1_LSB + STAMP_W;
  localparam int unsigned IN_T2_LSB  = IN_S2_LSB + SAMPLE_BITS;
  localparam int unsigned IN_W       = IN_T2_LSB + STAMP_W;
  localparam int unsigned IN_TDATA_W = ((IN_W + 7) / 8) * 8;
  localparam int unsigned IN_USER_W  = 2;

  // Output beat layout
  localparam int unsigned OUT_W       = 2 * (DIST_W + STAMP_W + 1) + STATUS_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILTER_ENABLE    = 3'd0,
    CFG_SMOOTHING_ALPHA  = 3'd1,
    CFG_DISTANCE_GAIN    = 3'd2,
    CFG_RANGE_SCALE      = 3'd3,
    CFG_DISTANCE_OFFSET  = 3'd4,
    CFG_SATURATION_LIMIT = 3'd5,
    CFG_LOW_LIMIT        = 3'd6
  } cfg_idx_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK           = 2'd0,
    STATUS_SATURATED    = 2'd1,
    STATUS_OUT_OF_RANGE = 2'd2
  } status_e;

  // Register reset values
  localparam logic                FEN_RST    = 1'b1;
  localparam logic [ALPHA_W-1:0]  ALPHA_RST  = 16'd49152;
  localparam logic [GAIN_W-1:0]   GAIN_RST   = 16'd256;
  localparam logic [SCALE_W-1:0]  SCALE_RST  = 16'd4095;
  localparam logic [OFFSET_W-1:0] OFFSET_RST = 32'd0;
  localparam logic [LIMIT_W-1:0]  SAT_RST    = 12'd4000;
  localparam logic [LIMIT_W-1:0]  LOW_RST    = 12'd100;

  localparam logic [DIST_W-1:0]   DIST_MAX   = {DIST_W{1'b1}};

endpackage

>>> sv/dual_ir_distance_ema.sv
// ----------------------------------------------------------------------------
// Dual IR distance front end with moving-average smoothing
// Smooths two photodiode samples, turns each into a Q16.16 distance, flags status.
// ----------------------------------------------------------------------------
// One input beat carries a sample and timestamp from each photodiode (ids in
// tuser); one output beat gives both held distances and timestamps, the fresh
// flags and the sensor status. The block takes one beat at a time. Each channel
// is first smoothed if the filter is enabled, then checked; if its id matches
// and its value is nonzero, the bit-serial ratio divide and the square root
// follow, both stepping through one shared compare-subtract unit, then the
// gain multiply and the offset add. Smoothing and gain use the one shared
// multiplier; the two channels run one after the other. A new input beat is
// taken once the result has moved into the output register.

`include "dual_ir_distance_ema_macros.svh"

module dual_ir_distance_ema (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [dide_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [dide_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // sample_one, stamp_one, sample_two, stamp_two, zero pad
  input  logic [dide_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // tag_one, tag_two
  input  logic [dide_pkg::IN_USER_W-1:0]      s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // distance_one, time_one, fresh_one, distance_two, time_two, fresh_two,
  // sensor_status, zero pad
  output logic [dide_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
  import dide_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SM_MUL,
    ST_SM_ADD,
    ST_CHECK,
    ST_DIV,
    ST_SQRT,
    ST_GAIN_MUL,
    ST_OFFSET,
    ST_FINISH
  } state_e;

  state_e                     state_q;
  logic                       ch_q;
  logic [CNT_W-1:0]           cnt_q;

  logic                       fen_q;
  logic [ALPHA_W-1:0]         alpha_q;
  logic [GAIN_W-1:0]          gain_q;
  logic [SCALE_W-1:0]         scale_q;
  logic [OFFSET_W-1:0]        offset_q;
  logic [LIMIT_W-1:0]         sat_lim_q;
  logic [LIMIT_W-1:0]         low_lim_q;

  logic [SAMPLE_BITS-1:0]     v_one_q, v_two_q;
  logic                       tag_one_q, tag_two_q;
  logic [SAMPLE_BITS-1:0]     sm_one_q, sm_two_q;
  logic [DIST_W-1:0]          kd_one_q, kd_two_q;
  logic [STAMP_W-1:0]         kt_one_q, kt_two_q;

  logic [NUM_W-1:0]           work_q;
  logic [REM_W-1:0]           rem_q;
  logic [ROOT_W-1:0]          root_q;
  logic signed [PROD_W-1:0]   prod_q;

  logic                       m_tvalid_q;
  logic [OUT_TDATA_W-1:0]     m_tdata_q;

  logic [SAMPLE_BITS-1:0]     cur_v, cur_sm, ema_v;
  logic                       cur_ok;
  logic signed [SAMPLE_BITS:0] sm_diff;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [PROD_W-1:0]   prod;
  logic [PROD_W-1:0]          ema_acc;
  logic [REM_W-1:0]           sub_a, sub_b, sub_res;
  logic [REM_W:0]             sub_diff;
  logic                       sub_ge;
  logic [DIST_W-1:0]          gain_d, dist_clamped;
  logic signed [SUM_W-1:0]    dist_sum;
  logic [CMP_W-1:0]           v1_c, v2_c, sat_c, low_c;
  status_e                    status_d;
  state_e                     adv_state;
  logic                       out_free;

  assign cur_v  = ch_q ? v_two_q  : v_one_q;
  assign cur_sm = ch_q ? sm_two_q : sm_one_q;
  assign cur_ok = ch_q ? tag_two_q : !tag_one_q;

  // Shared multiplier: alpha times (prev - x) for smoothing, gain times root later
  assign sm_diff = $signed({1'b0, cur_sm}) - $signed({1'b0, cur_v});

  always_comb begin
    if (state_q == ST_SM_MUL) begin
      mul_a = $signed({1'b0, alpha_q});
      mul_b = $signed({{(MUL_B_W-SAMPLE_BITS-1){sm_diff[SAMPLE_BITS]}}, sm_diff});
    end else begin
      mul_a = $signed({1'b0, gain_q});
      mul_b = $signed({1'b0, root_q});
    end
  end

  assign prod = mul_a * mul_b;

  // alpha*prev + (1-alpha)*x == x + alpha*(prev - x), all in Q.16
  assign ema_acc = $unsigned(prod_q)
                 + ({{(PROD_W-SAMPLE_BITS){1'b0}}, cur_v} << EMA_SHIFT);
  assign ema_v   = ema_acc[EMA_SHIFT +: SAMPLE_BITS];

  // Shared compare-subtract: restoring divide step or digit-by-digit root step
  always_comb begin
    if (state_q == ST_DIV) begin
      sub_a = {rem_q[REM_W-2:0], work_q[NUM_W-1]};
      sub_b = {{(REM_W-SAMPLE_BITS){1'b0}}, cur_v};
    end else begin
      sub_a = {rem_q[REM_W-3:0], work_q[NUM_W-1 -: 2]};
      sub_b = {1'b0, root_q, 2'b01};
    end
  end

  assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ge   = !sub_diff[REM_W];
  assign sub_res  = sub_ge ? sub_diff[REM_W-1:0] : sub_a;

  // Gain is Q8.8: drop eight bits, then add the signed offset and clamp
  assign gain_d   = prod_q[GAIN_SHIFT +: DIST_W];
  assign dist_sum = $signed({2'b00, gain_d})
                  + $signed({{(SUM_W-OFFSET_W){offset_q[OFFSET_W-1]}}, offset_q});

  always_comb begin
    if (dist_sum[SUM_W-1]) begin
      dist_clamped = '0;
    end else if (dist_sum[SUM_W-2]) begin
      dist_clamped = DIST_MAX;
    end else begin
      dist_clamped = dist_sum[DIST_W-1:0];
    end
  end

  assign v1_c  = {{(CMP_W-SAMPLE_BITS){1'b0}}, v_one_q};
  assign v2_c  = {{(CMP_W-SAMPLE_BITS){1'b0}}, v_two_q};
  assign sat_c = {{(CMP_W-LIMIT_W){1'b0}}, sat_lim_q};
  assign low_c = {{(CMP_W-LIMIT_W){1'b0}}, low_lim_q};

  always_comb begin
    if (v1_c >= sat_c || v2_c >= sat_c) begin
      status_d = STATUS_SATURATED;
    end else if (v1_c <= low_c || v2_c <= low_c) begin
      status_d = STATUS_OUT_OF_RANGE;
    end else begin
      status_d = STATUS_OK;
    end
  end

  // After a channel: start the second one, or finish after it
  assign adv_state = !ch_q ? (fen_q ? ST_SM_MUL : ST_CHECK) : ST_FINISH;
  assign out_free  = !m_tvalid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      ch_q       <= 1'b0;
      cnt_q      <= '0;
      fen_q      <= FEN_RST;
      alpha_q    <= ALPHA_RST;
      gain_q     <= GAIN_RST;
      scale_q    <= SCALE_RST;
      offset_q   <= OFFSET_RST;
      sat_lim_q  <= SAT_RST;
      low_lim_q  <= LOW_RST;
      v_one_q    <= '0;
      v_two_q    <= '0;
      tag_one_q  <= 1'b0;
      tag_two_q  <= 1'b0;
      sm_one_q   <= '0;
      sm_two_q   <= '0;
      kd_one_q   <= '0;
      kd_two_q   <= '0;
      kt_one_q   <= '0;
      kt_two_q   <= '0;
      work_q     <= '0;
      rem_q      <= '0;
      root_q     <= '0;
      prod_q     <= '0;
      m_tvalid_q <= 1'b0;
      m_tdata_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_FILTER_ENABLE:    fen_q     <= cfg_data_i[0];
          CFG_SMOOTHING_ALPHA:  alpha_q   <= cfg_data_i[ALPHA_W-1:0];
          CFG_DISTANCE_GAIN:    gain_q    <= cfg_data_i[GAIN_W-1:0];
          CFG_RANGE_SCALE:      scale_q   <= cfg_data_i[SCALE_W-1:0];
          CFG_DISTANCE_OFFSET:  offset_q  <= cfg_data_i[OFFSET_W-1:0];
          CFG_SATURATION_LIMIT: sat_lim_q <= cfg_data_i[LIMIT_W-1:0];
          CFG_LOW_LIMIT:        low_lim_q <= cfg_data_i[LIMIT_W-1:0];
          default: ;
        endcase
      end

      if (m_tvalid_q && m_axis_tready) begin
        m_tvalid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            v_one_q   <= s_axis_tdata[IN_S1_LSB +: SAMPLE_BITS];
            v_two_q   <= s_axis_tdata[IN_S2_LSB +: SAMPLE_BITS];
            tag_one_q <= s_axis_tuser[0];
            tag_two_q <= s_axis_tuser[1];
            // Timestamps follow their channel's id check straight away
            if (!s_axis_tuser[0]) begin
              kt_one_q <= s_axis_tdata[IN_T1_LSB +: STAMP_W];
            end
            if (s_axis_tuser[1]) begin
              kt_two_q <= s_axis_tdata[IN_T2_LSB +: STAMP_W];
            end
            ch_q    <= 1'b0;
            state_q <= fen_q ? ST_SM_MUL : ST_CHECK;
          end
        end
        ST_SM_MUL: begin
          prod_q  <= prod;
          state_q <= ST_SM_ADD;
        end
        ST_SM_ADD: begin
          if (ch_q) begin
            v_two_q  <= ema_v;
            sm_two_q <= ema_v;
          end else begin
            v_one_q  <= ema_v;
            sm_one_q <= ema_v;
          end
          state_q <= ST_CHECK;
        end
        ST_CHECK: begin
          if (!cur_ok) begin
            ch_q    <= 1'b1;
            state_q <= adv_state;
          end else if (cur_v == '0) begin
            // Zero sample reads as the far end of the range
            if (ch_q) begin
              kd_two_q <= DIST_MAX;
            end else begin
              kd_one_q <= DIST_MAX;
            end
            ch_q    <= 1'b1;
            state_q <= adv_state;
          end else begin
            work_q  <= {scale_q, {FRAC_W{1'b0}}};
            rem_q   <= '0;
            cnt_q   <= '0;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          // Quotient bits shift in where numerator bits shift out
          work_q <= {work_q[NUM_W-2:0], sub_ge};
          rem_q  <= sub_res;
          cnt_q  <= cnt_q + CNT_W'(1);
          if (cnt_q == CNT_W'(NUM_W - 1)) begin
            rem_q   <= '0;
            root_q  <= '0;
            cnt_q   <= '0;
            state_q <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          work_q <= {work_q[NUM_W-3:0], 2'b00};
          rem_q  <= sub_res;
          root_q <= {root_q[ROOT_W-2:0], sub_ge};
          cnt_q  <= cnt_q + CNT_W'(1);
          if (cnt_q == CNT_W'(ROOT_W - 1)) begin
            state_q <= ST_GAIN_MUL;
          end
        end
        ST_GAIN_MUL: begin
          prod_q  <= prod;
          state_q <= ST_OFFSET;
        end
        ST_OFFSET: begin
          if (ch_q) begin
            kd_two_q <= dist_clamped;
          end else begin
            kd_one_q <= dist_clamped;
          end
          ch_q    <= 1'b1;
          state_q <= adv_state;
        end
        ST_FINISH: begin
          // Hold until the output register is free
          if (out_free) begin
            m_tdata_q  <= OUT_TDATA_W'({status_d, tag_two_q, kt_two_q, kd_two_q,
                                        !tag_one_q, kt_one_q, kd_one_q});
            m_tvalid_q <= 1'b1;
            state_q    <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;

  `DIDE_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input accepted while still busy")
  `DIDE_ASSERT_NOW(a_div_rem_bound, state_q == ST_DIV, rem_q < REM_W'(cur_v), "divide remainder not below divisor")
  `DIDE_ASSERT_NEXT(a_finish_delivers, state_q == ST_FINISH && out_free, m_axis_tvalid && state_q == ST_IDLE, "finished result not presented")

endmodule

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// Dual IR distance front end testbench
// Feeds paired photodiode beats through the smoothing and distance block under
// several register settings, predicts every result beat in step with the block
// and compares each field. Sender gaps, receiver stalls and one long receiver
// hold-off exercise the handshakes on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import dide_pkg::*;

  localparam logic TAG_ONE_ID = 1'b0;
  localparam logic TAG_TWO_ID = 1'b1;
  localparam int   SAMPLE_TOP = (1 << SAMPLE_BITS) - 1;
  localparam int unsigned HOLD_CYCLES = 2000;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample_one;
    logic                   tag_one;
    logic [STAMP_W-1:0]     stamp_one;
    logic [SAMPLE_BITS-1:0] sample_two;
    logic                   tag_two;
    logic [STAMP_W-1:0]     stamp_two;
  } photo_pair_t;

  // Result beat layout, highest field first
  typedef struct packed {
    status_e             status;
    logic                fresh_two;
    logic [STAMP_W-1:0]  time_two;
    logic [DIST_W-1:0]   distance_two;
    logic                fresh_one;
    logic [STAMP_W-1:0]  time_one;
    logic [DIST_W-1:0]   distance_one;
  } reading_t;

  typedef struct {
    logic                       fen;
    logic [ALPHA_W-1:0]         alpha;
    logic [GAIN_W-1:0]          gain;
    logic [SCALE_W-1:0]         scale;
    logic signed [OFFSET_W-1:0] offset;
    logic [LIMIT_W-1:0]         sat;
    logic [LIMIT_W-1:0]         low;
  } filter_cfg_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_idx_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic [IN_USER_W-1:0]   s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // Predictor copy of the registers and of the block state
  filter_cfg_t            cur;
  logic [SAMPLE_BITS-1:0] ema_one, ema_two;
  logic [DIST_W-1:0]      held_dist_one, held_dist_two;
  logic [STAMP_W-1:0]     held_time_one, held_time_two;

  reading_t    pending_readings[$];
  int          fail_count = 0;
  int unsigned burst_left = 0;
  logic        hold_request = 1'b0;

  always #5 clk_i = ~clk_i;

  dual_ir_distance_ema i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic logic [SAMPLE_BITS-1:0] ema_update(logic [SAMPLE_BITS-1:0] prev,
                                                        logic [SAMPLE_BITS-1:0] x);
    logic [33:0] acc;
    acc = 34'(cur.alpha) * 34'(prev) + (34'd65536 - 34'(cur.alpha)) * 34'(x);
    return acc[EMA_SHIFT +: SAMPLE_BITS];
  endfunction

  function automatic logic [DIST_W-1:0] sample_to_distance(logic [SAMPLE_BITS-1:0] v);
    logic [47:0] ratio;
    logic [23:0] root, trial;
    logic [39:0] scaled;
    longint      sum;
    if (v == 0) return DIST_MAX;
    ratio = {cur.scale, 32'd0} / 48'(v);
    root = '0;
    // settle the root one bit at a time from the top
    for (int b = 23; b >= 0; b--) begin
      trial = root | (24'd1 << b);
      if (48'(trial) * 48'(trial) <= ratio) root = trial;
    end
    scaled = (40'(cur.gain) * 40'(root)) >> GAIN_SHIFT;
    sum = longint'(scaled) + longint'(cur.offset);
    if (sum < 0) return '0;
    if (sum > longint'(32'hFFFF_FFFF)) return DIST_MAX;
    return DIST_W'(sum);
  endfunction

  function automatic reading_t predict_reading(photo_pair_t p);
    reading_t               r;
    logic [SAMPLE_BITS-1:0] v1, v2;
    v1 = p.sample_one;
    v2 = p.sample_two;
    if (cur.fen) begin
      v1 = ema_update(ema_one, v1);
      v2 = ema_update(ema_two, v2);
      ema_one = v1;
      ema_two = v2;
    end
    if (p.tag_one == TAG_ONE_ID) begin
      held_dist_one = sample_to_distance(v1);
      held_time_one = p.stamp_one;
    end
    if (p.tag_two == TAG_TWO_ID) begin
      held_dist_two = sample_to_distance(v2);
      held_time_two = p.stamp_two;
    end
    // a channel with a foreign tag still counts towards the status
    if (v1 >= cur.sat || v2 >= cur.sat) r.status = STATUS_SATURATED;
    else if (v1 <= cur.low || v2 <= cur.low) r.status = STATUS_OUT_OF_RANGE;
    else r.status = STATUS_OK;
    r.distance_one = held_dist_one;
    r.time_one     = held_time_one;
    r.fresh_one    = (p.tag_one == TAG_ONE_ID);
    r.distance_two = held_dist_two;
    r.time_two     = held_time_two;
    r.fresh_two    = (p.tag_two == TAG_TWO_ID);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s expected %0h actual %0h", field, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin : reading_check
    reading_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = reading_t'(m_axis_tdata[OUT_W-1:0]);
      if (pending_readings.size() == 0) begin
        $error("result beat with nothing expected: %h", got);
        fail_count++;
      end else begin
        want = pending_readings.pop_front();
        check_field("distance_one", want.distance_one, got.distance_one);
        check_field("time_one", want.time_one, got.time_one);
        check_field("fresh_one", 32'(want.fresh_one), 32'(got.fresh_one));
        check_field("distance_two", want.distance_two, got.distance_two);
        check_field("time_two", want.time_two, got.time_two);
        check_field("fresh_two", 32'(want.fresh_two), 32'(got.fresh_two));
        check_field("sensor_status", 32'(want.status), 32'(got.status));
      end
    end
  end

  // Receiver: stall on a rotating pattern, all-ready now and then, and hold
  // off for a long stretch when asked
  initial begin : result_sink
    logic [15:0] ready_pattern;
    int unsigned tick;
    int unsigned hold_left;
    m_axis_tready = 1'b0;
    ready_pattern = '1;
    tick = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (tick % 64 == 0)
        ready_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h1);
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ready_pattern[tick % 16];
      end
      tick++;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic send_pair(input photo_pair_t p);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 160) : $urandom_range(1, 6);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 12);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'({p.stamp_two, p.sample_two, p.stamp_one, p.sample_one});
    s_axis_tuser  <= {p.tag_two, p.tag_one};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_readings.push_back(predict_reading(p));
    burst_left--;
  endtask

  task automatic stop_sending();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
  endtask

  // Wait for every result beat, then let the block go quiet
  task automatic settle();
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apply_settings(input filter_cfg_t c);
    cfg_idx_e k;
    k = k.first();
    @(posedge clk_i);
    do begin
      cfg_we_i  <= 1'b1;
      cfg_idx_i <= k;
      case (k)
        CFG_FILTER_ENABLE:    cfg_data_i <= CFG_DATA_W'(c.fen);
        CFG_SMOOTHING_ALPHA:  cfg_data_i <= CFG_DATA_W'(c.alpha);
        CFG_DISTANCE_GAIN:    cfg_data_i <= CFG_DATA_W'(c.gain);
        CFG_RANGE_SCALE:      cfg_data_i <= CFG_DATA_W'(c.scale);
        CFG_DISTANCE_OFFSET:  cfg_data_i <= CFG_DATA_W'(c.offset);
        CFG_SATURATION_LIMIT: cfg_data_i <= CFG_DATA_W'(c.sat);
        default:              cfg_data_i <= CFG_DATA_W'(c.low);
      endcase
      @(posedge clk_i);
      k = k.next();
    end while (k != k.first());
    cfg_we_i <= 1'b0;
    cur = c;
  endtask

  function automatic filter_cfg_t settings_of(logic fen, int unsigned alpha, int unsigned gain,
                                              int unsigned scale, logic [31:0] offset,
                                              int unsigned sat, int unsigned low);
    filter_cfg_t c;
    c.fen    = fen;
    c.alpha  = ALPHA_W'(alpha);
    c.gain   = GAIN_W'(gain);
    c.scale  = SCALE_W'(scale);
    c.offset = offset;
    c.sat    = LIMIT_W'(sat);
    c.low    = LIMIT_W'(low);
    return c;
  endfunction

  function automatic filter_cfg_t random_settings();
    filter_cfg_t c;
    c.fen = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0:       c.alpha = '0;
      1:       c.alpha = '1;
      default: c.alpha = ALPHA_W'($urandom);
    endcase
    case ($urandom_range(0, 4))
      0:       c.gain = '0;
      1:       c.gain = '1;
      2:       c.gain = GAIN_RST;
      default: c.gain = GAIN_W'($urandom);
    endcase
    case ($urandom_range(0, 3))
      0:       c.scale = '0;
      1:       c.scale = '1;
      default: c.scale = SCALE_W'($urandom);
    endcase
    // small or zero offsets half the time, so that distances are not all clamped
    case ($urandom_range(0, 5))
      0:       c.offset = 32'h8000_0000;
      1:       c.offset = 32'h7FFF_FFFF;
      2:       c.offset = '0;
      3, 4:    c.offset = 32'($urandom_range(0, 2 ** 21)) - 32'(2 ** 20);
      default: c.offset = $urandom;
    endcase
    c.sat = ($urandom_range(0, 5) == 0) ? LIMIT_W'($urandom)
                                        : LIMIT_W'($urandom_range(2048, 4095));
    c.low = ($urandom_range(0, 5) == 0) ? LIMIT_W'($urandom)
                                        : LIMIT_W'($urandom_range(0, 1024));
    return c;
  endfunction

  function automatic photo_pair_t pair_of(int unsigned s1, logic t1, logic [31:0] st1,
                                          int unsigned s2, logic t2, logic [31:0] st2);
    photo_pair_t p;
    p.sample_one = SAMPLE_BITS'(s1);
    p.tag_one    = t1;
    p.stamp_one  = st1;
    p.sample_two = SAMPLE_BITS'(s2);
    p.tag_two    = t2;
    p.stamp_two  = st2;
    return p;
  endfunction

  // Bias towards zero, full scale and the current limits
  function automatic logic [SAMPLE_BITS-1:0] random_sample();
    int v;
    case ($urandom_range(0, 9))
      0:       v = 0;
      1:       v = SAMPLE_TOP;
      2:       v = int'(cur.sat) + int'($urandom_range(0, 2)) - 1;
      3:       v = int'(cur.low) + int'($urandom_range(0, 2)) - 1;
      default: v = int'($urandom_range(0, SAMPLE_TOP));
    endcase
    if (v < 0) v = 0;
    if (v > SAMPLE_TOP) v = SAMPLE_TOP;
    return SAMPLE_BITS'(v);
  endfunction

  function automatic photo_pair_t random_pair();
    photo_pair_t p;
    p.sample_one = random_sample();
    p.tag_one    = ($urandom_range(0, 4) == 0) ? ~TAG_ONE_ID : TAG_ONE_ID;
    p.stamp_one  = $urandom;
    p.sample_two = random_sample();
    p.tag_two    = ($urandom_range(0, 4) == 0) ? ~TAG_TWO_ID : TAG_TWO_ID;
    p.stamp_two  = $urandom;
    return p;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_reset_values();
    send_pair(pair_of(0, TAG_ONE_ID, 32'h0, 0, TAG_TWO_ID, 32'hFFFF_FFFF));
    send_pair(pair_of(SAMPLE_TOP, TAG_ONE_ID, 32'hFFFF_FFFF, SAMPLE_TOP, TAG_TWO_ID, 32'h0));
    send_pair(pair_of(SAMPLE_TOP, TAG_ONE_ID, 32'h1234_5678, SAMPLE_TOP, TAG_TWO_ID,
                      32'h8765_4321));
    send_pair(pair_of(2000, ~TAG_ONE_ID, 32'hAAAA_AAAA, 2000, ~TAG_TWO_ID, 32'h5555_5555));
    send_pair(pair_of(300, ~TAG_ONE_ID, 32'h0000_0001, 300, TAG_TWO_ID, 32'h8000_0000));
    send_pair(pair_of(3000, TAG_ONE_ID, 32'h7FFF_FFFF, 3000, ~TAG_TWO_ID, 32'hFFFF_FFFE));
    stop_sending();
    settle();
  endtask

  task automatic test_register_extremes();
    // raw samples, widest ratio, sum above range
    apply_settings(settings_of(1'b0, 0, 65535, 65535, 32'h7FFF_FFFF, 4095, 0));
    send_pair(pair_of(1, TAG_ONE_ID, 32'h1, 1, TAG_TWO_ID, 32'h2));
    send_pair(pair_of(0, TAG_ONE_ID, 32'h3, SAMPLE_TOP, TAG_TWO_ID, 32'h4));
    send_pair(pair_of(SAMPLE_TOP, TAG_ONE_ID, 32'h5, 2048, TAG_TWO_ID, 32'h6));
    send_pair(pair_of(2048, TAG_ONE_ID, 32'h7, 1, TAG_TWO_ID, 32'h8));
    stop_sending();
    settle();
    // zero scale with the most negative offset clamps to zero
    apply_settings(settings_of(1'b0, 65535, 1, 0, 32'h8000_0000, 0, 4095));
    send_pair(pair_of(0, TAG_ONE_ID, 32'h9, SAMPLE_TOP, TAG_TWO_ID, 32'hA));
    send_pair(pair_of(5, TAG_ONE_ID, 32'hB, 0, TAG_TWO_ID, 32'hC));
    send_pair(pair_of(SAMPLE_TOP, TAG_ONE_ID, 32'hD, 5, TAG_TWO_ID, 32'hE));
    stop_sending();
    settle();
    // heaviest weight on the previous value: output barely moves
    apply_settings(settings_of(1'b1, 65535, 256, 4095, 32'h0, 4000, 100));
    send_pair(pair_of(SAMPLE_TOP, TAG_ONE_ID, 32'hF, SAMPLE_TOP, TAG_TWO_ID, 32'h10));
    send_pair(pair_of(SAMPLE_TOP, TAG_ONE_ID, 32'h11, 0, TAG_TWO_ID, 32'h12));
    stop_sending();
    settle();
    // no weight on the previous value: limits at their edges
    apply_settings(settings_of(1'b1, 0, 256, 4095, 32'hFFFF_0000, 4000, 100));
    send_pair(pair_of(SAMPLE_TOP, TAG_ONE_ID, 32'h13, 101, TAG_TWO_ID, 32'h14));
    send_pair(pair_of(100, TAG_ONE_ID, 32'h15, 3999, TAG_TWO_ID, 32'h16));
    send_pair(pair_of(101, TAG_ONE_ID, 32'h17, 3999, TAG_TWO_ID, 32'h18));
    send_pair(pair_of(4000, ~TAG_ONE_ID, 32'h19, 101, TAG_TWO_ID, 32'h1A));
    send_pair(pair_of(3999, TAG_ONE_ID, 32'h1B, 2, ~TAG_TWO_ID, 32'h1C));
    stop_sending();
    settle();
  endtask

  // Hold the result side off while beats keep coming, so the input stalls
  task automatic test_backpressure();
    apply_settings(random_settings());
    hold_request = 1'b1;
    repeat (40) send_pair(random_pair());
    stop_sending();
    settle();
  endtask

  task automatic test_random_settings();
    filter_cfg_t c;
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 0) c = settings_of(1'b0, 0, 0, 0, 32'h8000_0000, 0, 0);
      else if (ph == 1) c = settings_of(1'b1, 65535, 65535, 65535, 32'h7FFF_FFFF, 4095, 4095);
      else c = random_settings();
      apply_settings(c);
      repeat (230) send_pair(random_pair());
      stop_sending();
      settle();
    end
  endtask

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_FILTER_ENABLE;
    cfg_data_i    = '0;
    rst_ni        = 1'b0;
    cur = settings_of(FEN_RST, ALPHA_RST, GAIN_RST, SCALE_RST, OFFSET_RST, SAT_RST, LOW_RST);
    ema_one = '0;
    ema_two = '0;
    held_dist_one = '0;
    held_dist_two = '0;
    held_time_one = '0;
    held_time_two = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_values();
    test_register_extremes();
    test_backpressure();
    test_random_settings();

    // let any stray result beat show up
    repeat (200) @(posedge clk_i);
    if (fail_count == 0 && pending_readings.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #(25_000_000);
    $display("testbench: FAIL");
    $finish;
  end

endmodule
